// ===== hdl/cff_pkg.sv =====
// shared types and constants for the contact friction force block
// beat layouts, per-lane divider state and fixed field widths; no dependencies
`default_nettype none

package cff_pkg;

	localparam int DISP_W    = 32;  // signed displacement and force fields
	localparam int COEF_W    = 31;  // unsigned stiffness, coefficient and normal force
	localparam int DIV_STEPS = 32;  // quotient bits produced by the slider divider
	localparam int LANE_LAT  = 39;  // register stages from accept to lane result
	localparam int IN_W      = 352;
	localparam int OUT_W     = 160;

	localparam logic [DISP_W-1:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [DISP_W-1:0] S32_MIN = 32'h8000_0000;

	// input beat, first field in the lowest bits
	typedef struct packed {
		logic [DISP_W-1:0] slider_in_b;
		logic [DISP_W-1:0] slider_in_a;
		logic [COEF_W-1:0] fric_coef_b;
		logic [COEF_W-1:0] fric_coef_a;
		logic [COEF_W-1:0] tang_stiff_b;
		logic [COEF_W-1:0] tang_stiff_a;
		logic [DISP_W-1:0] tang_disp_b;
		logic [DISP_W-1:0] tang_disp_a;
		logic [DISP_W-1:0] normal_gap;
		logic [COEF_W-1:0] normal_stiffness;
		logic [DISP_W-1:0] normal_disp;
	} in_beat_t;

	// result beat, first field in the lowest bits
	typedef struct packed {
		logic [DISP_W-1:0] slider_out_b;
		logic [DISP_W-1:0] slider_out_a;
		logic [DISP_W-1:0] tang_force_b;
		logic [DISP_W-1:0] tang_force_a;
		logic [COEF_W-1:0] normal_force;
	} res_t;

	// what one tangential lane takes from the input beat
	typedef struct packed {
		logic [COEF_W-1:0] fric_coef;
		logic [COEF_W-1:0] tang_stiff;
		logic [DISP_W-1:0] slider_in;
		logic [DISP_W-1:0] tang_disp;
	} lane_in_t;

	// state carried through the restoring divider stages
	typedef struct packed {
		logic [COEF_W-1:0] rem;
		logic [DISP_W-1:0] quo;
		logic [DISP_W-1:0] low;
		logic [COEF_W-1:0] kt;
		logic [DISP_W-1:0] xt;
		logic [DISP_W-1:0] byval;
		logic [DISP_W-1:0] frc;
		logic              neg;
		logic              ovf;
		logic              bypass;
	} div_t;

endpackage

`default_nettype wire

// ===== hdl/cff_div_step.sv =====
// one registered step of the restoring slider divider
// uses cff_pkg for the divider state type
`default_nettype none

module cff_div_step
	import cff_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  div_t d_in,
	output div_t d_out
);

	logic [DISP_W-1:0] r;
	logic              ge;
	div_t              nxt;

	always_comb begin
		r       = {d_in.rem, d_in.low[DISP_W-1]};
		ge      = (r >= {1'b0, d_in.kt});
		nxt     = d_in;
		nxt.rem = ge ? COEF_W'(r - {1'b0, d_in.kt}) : r[COEF_W-1:0];
		nxt.quo = {d_in.quo[DISP_W-2:0], ge};
		nxt.low = {d_in.low[DISP_W-2:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cff_lane.sv =====
// one tangential direction: trial force, stick/slip decision and slider update
// uses cff_pkg and cff_div_step; the normal force arrives from the top level
`default_nettype none

module cff_lane
	import cff_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              en,
	input  lane_in_t          lin,
	input  logic [COEF_W-1:0] fn,      // normal force, valid at stage 4 input
	output logic [DISP_W-1:0] frc,
	output logic [DISP_W-1:0] slider
);

	localparam int SAT_B    = (WORD_BITS < DISP_W) ? WORD_BITS : DISP_W;
	localparam logic [COEF_W-1:0] SAT_MAX = COEF_W'((64'd1 << (SAT_B - 1)) - 64'd1);
	localparam int PROD_T_W = DISP_W + COEF_W;
	localparam int PROD_L_W = 2 * COEF_W;
	localparam int TRIAL_W  = PROD_T_W - FRAC_BITS;
	localparam int LIM_W    = PROD_L_W - FRAC_BITS;
	localparam int NUM_W    = COEF_W + FRAC_BITS;
	localparam int TOP_W    = NUM_W - DISP_W;

	// stage 1: displacement difference
	logic [DISP_W:0]   diff;
	logic [DISP_W-1:0] dmag_s1, xt_s1, w_s1;
	logic              dneg_s1, dpos_s1;
	logic [COEF_W-1:0] kt_s1, mu_s1;

	assign diff = {lin.tang_disp[DISP_W-1], lin.tang_disp}
		- {lin.slider_in[DISP_W-1], lin.slider_in};

	always_ff @(posedge clk) begin
		if (en) begin
			dneg_s1 <= diff[DISP_W];
			dpos_s1 <= !diff[DISP_W] && (diff != '0);
			dmag_s1 <= diff[DISP_W] ? DISP_W'(-diff) : diff[DISP_W-1:0];
			xt_s1   <= lin.tang_disp;
			w_s1    <= lin.slider_in;
			kt_s1   <= lin.tang_stiff;
			mu_s1   <= lin.fric_coef;
		end
	end

	// stage 2: trial force product
	logic [PROD_T_W-1:0] tprod_s2;
	logic [DISP_W-1:0]   xt_s2, w_s2;
	logic                dneg_s2, dpos_s2;
	logic [COEF_W-1:0]   kt_s2, mu_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			tprod_s2 <= PROD_T_W'(dmag_s1) * PROD_T_W'(kt_s1);
			dneg_s2  <= dneg_s1;
			dpos_s2  <= dpos_s1;
			xt_s2    <= xt_s1;
			w_s2     <= w_s1;
			kt_s2    <= kt_s1;
			mu_s2    <= mu_s1;
		end
	end

	// stage 3: scale trial force
	logic [TRIAL_W-1:0] trial_s3;
	logic [DISP_W-1:0]  xt_s3, w_s3;
	logic               dneg_s3, dpos_s3;
	logic [COEF_W-1:0]  kt_s3, mu_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			trial_s3 <= tprod_s2[PROD_T_W-1:FRAC_BITS];
			dneg_s3  <= dneg_s2;
			dpos_s3  <= dpos_s2;
			xt_s3    <= xt_s2;
			w_s3     <= w_s2;
			kt_s3    <= kt_s2;
			mu_s3    <= mu_s2;
		end
	end

	// stage 4: friction limit product
	logic [PROD_L_W-1:0] lprod_s4;
	logic [TRIAL_W-1:0]  trial_s4;
	logic [DISP_W-1:0]   xt_s4, w_s4;
	logic                dneg_s4, dpos_s4;
	logic [COEF_W-1:0]   kt_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			lprod_s4 <= PROD_L_W'(mu_s3) * PROD_L_W'(fn);
			trial_s4 <= trial_s3;
			dneg_s4  <= dneg_s3;
			dpos_s4  <= dpos_s3;
			xt_s4    <= xt_s3;
			w_s4     <= w_s3;
			kt_s4    <= kt_s3;
		end
	end

	// stage 5: stick or slip, saturated force
	logic [LIM_W-1:0]  lim;
	logic              stick, neg;
	logic [COEF_W-1:0] tsat, lsat, mag;

	always_comb begin
		lim   = lprod_s4[PROD_L_W-1:FRAC_BITS];
		stick = (trial_s4 < TRIAL_W'(lim));
		tsat  = (trial_s4 > TRIAL_W'(SAT_MAX)) ? SAT_MAX : trial_s4[COEF_W-1:0];
		lsat  = (lim > LIM_W'(SAT_MAX)) ? SAT_MAX : lim[COEF_W-1:0];
		mag   = stick ? tsat : lsat;
		neg   = stick ? dneg_s4 : !(dpos_s4 && (trial_s4 != '0));
	end

	logic [COEF_W-1:0] mag_s5, kt_s5;
	logic [DISP_W-1:0] frc_s5, byval_s5, xt_s5;
	logic              neg_s5, bypass_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5    <= mag;
			neg_s5    <= neg;
			frc_s5    <= neg ? DISP_W'(-{1'b0, mag}) : {1'b0, mag};
			// stick keeps the slider, zero slip force or stiffness takes the displacement
			bypass_s5 <= stick || (lsat == '0) || (kt_s4 == '0);
			byval_s5  <= stick ? w_s4 : xt_s4;
			xt_s5     <= xt_s4;
			kt_s5     <= kt_s4;
		end
	end

	// stage 6: divider setup, quotient beyond 32 bits saturates the slider anyway
	logic [NUM_W-1:0] num;
	logic [TOP_W-1:0] num_top;
	logic             ovf;
	div_t             div_s6;

	always_comb begin
		num     = {mag_s5, {FRAC_BITS{1'b0}}};
		num_top = num[NUM_W-1:DISP_W];
		ovf     = (COEF_W'(num_top) >= kt_s5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s6.rem    <= ovf ? '0 : COEF_W'(num_top);
			div_s6.quo    <= '0;
			div_s6.low    <= num[DISP_W-1:0];
			div_s6.kt     <= kt_s5;
			div_s6.xt     <= xt_s5;
			div_s6.byval  <= byval_s5;
			div_s6.frc    <= frc_s5;
			div_s6.neg    <= neg_s5;
			div_s6.ovf    <= ovf;
			div_s6.bypass <= bypass_s5;
		end
	end

	// stages 7 to 38: one quotient bit per stage
	div_t div_stg [DIV_STEPS+1];

	assign div_stg[0] = div_s6;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		cff_div_step u_step (
			.clk  (clk),
			.en   (en),
			.d_in (div_stg[i]),
			.d_out(div_stg[i+1])
		);
	end

	// stage 39: slider update with saturation
	div_t              dl;
	logic [DISP_W+1:0] xt_ext, q_ext, sum;
	logic [DISP_W-1:0] sum_sat, w_new;

	always_comb begin
		dl      = div_stg[DIV_STEPS];
		xt_ext  = {{2{dl.xt[DISP_W-1]}}, dl.xt};
		q_ext   = {2'b00, dl.quo};
		sum     = dl.neg ? (xt_ext + q_ext) : (xt_ext - q_ext);
		if ((sum[DISP_W+1:DISP_W-1] == 3'b000) || (sum[DISP_W+1:DISP_W-1] == 3'b111)) begin
			sum_sat = sum[DISP_W-1:0];
		end else begin
			sum_sat = sum[DISP_W+1] ? S32_MIN : S32_MAX;
		end
		if (dl.bypass) begin
			w_new = dl.byval;
		end else if (dl.ovf) begin
			w_new = dl.neg ? S32_MAX : S32_MIN;
		end else begin
			w_new = sum_sat;
		end
	end

	logic [DISP_W-1:0] frc_s39, slider_s39;

	always_ff @(posedge clk) begin
		if (en) begin
			frc_s39    <= dl.frc;
			slider_s39 <= w_new;
		end
	end

	assign frc    = frc_s39;
	assign slider = slider_s39;

endmodule

`default_nettype wire

// ===== hdl/cff_skid.sv =====
// output register with a skid stage for the result stream
// uses cff_pkg for the result beat type
`default_nettype none

module cff_skid
	import cff_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  res_t in_data,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (out_v_q && !out_ready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (in_valid) begin
			if (out_v_q && !out_ready) begin
				skid_q <= in_data;
			end else begin
				out_q <= in_data;
			end
		end
	end

	assign in_ready  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a beat while the output register is empty");

endmodule

`default_nettype wire

// ===== hdl/contact_friction_force.sv =====
// contact_friction_force: Jenkins element with Coulomb friction at one contact point
// top level; uses cff_pkg, cff_lane (two tangential lanes) and cff_skid
//
// usage
//   s_axis carries one contact point per beat, m_axis one result per beat, in order.
//   normal force is max(0, kn*(xn-gap)) saturated; each tangential lane forms
//   kt*(xt-w), keeps it while below mu*FN (stick) or clips it to +/-mu*FN and
//   moves the slider (slip). all values are Q16.16 by default (FRAC_BITS).
//   throughput: one beat per cycle, sustained, as long as m_axis_tready is high.
//   the delay from the accepting edge to m_axis_tvalid is set by the slider update,
//   a restoring divider of 32 registered one-bit steps per lane, behind the
//   normal force product and two multiplier stages for trial and limit.
//   all stages move together on one enable; the two lanes and the normal path
//   run side by side and are merged into the output beat at the last stage.
//   stall: while a result waits, the pipeline advances one more beat into the
//   skid register, then s_axis_tready drops (registered, no path from m_axis_tready)
//   and everything holds until the output is taken.
//   reset: arst_n clears every valid bit, also those of the output and skid
//   registers; the block comes out of reset empty and ready.
`default_nettype none

module contact_friction_force
	import cff_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// normal_disp, normal_stiffness, normal_gap, tang_disp_a, tang_disp_b,
	// tang_stiff_a, tang_stiff_b, fric_coef_a, fric_coef_b, slider_in_a,
	// slider_in_b, zero fill
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// normal_force, tang_force_a, tang_force_b, slider_out_a, slider_out_b, zero fill
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int SAT_B    = (WORD_BITS < DISP_W) ? WORD_BITS : DISP_W;
	localparam logic [COEF_W-1:0] SAT_MAX = COEF_W'((64'd1 << (SAT_B - 1)) - 64'd1);
	localparam int PROD_N_W = DISP_W + COEF_W;
	localparam int FN_RAW_W = PROD_N_W - FRAC_BITS;
	localparam int LAT      = LANE_LAT;

	in_beat_t ib;
	logic     en;   // whole pipeline advances together

	assign ib            = s_axis_tdata[$bits(in_beat_t)-1:0];
	assign s_axis_tready = en;

	// valid bit per stage
	logic [LAT:1] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], s_axis_tvalid};
		end
	end

	// normal path, stage 1: penetration
	logic [DISP_W:0]   udiff;
	logic [DISP_W-1:0] umag_s1;
	logic              upos_s1;
	logic [COEF_W-1:0] kn_s1;

	assign udiff = {ib.normal_disp[DISP_W-1], ib.normal_disp}
		- {ib.normal_gap[DISP_W-1], ib.normal_gap};

	always_ff @(posedge clk) begin
		if (en) begin
			upos_s1 <= !udiff[DISP_W] && (udiff != '0);
			umag_s1 <= udiff[DISP_W-1:0];
			kn_s1   <= ib.normal_stiffness;
		end
	end

	// stage 2: normal force product, zero when out of contact
	logic [PROD_N_W-1:0] nprod_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			nprod_s2 <= upos_s1 ? (PROD_N_W'(umag_s1) * PROD_N_W'(kn_s1)) : '0;
		end
	end

	// stage 3: scale and saturate
	logic [FN_RAW_W-1:0] fn_raw;
	logic [COEF_W-1:0]   fn_s3;

	assign fn_raw = nprod_s2[PROD_N_W-1:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			fn_s3 <= (fn_raw > FN_RAW_W'(SAT_MAX)) ? SAT_MAX : fn_raw[COEF_W-1:0];
		end
	end

	// normal force rides alongside the lanes to the merge stage
	logic [COEF_W-1:0] fn_stg [4:LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			fn_stg[4] <= fn_s3;
			for (int i = 5; i <= LAT; i++) begin
				fn_stg[i] <= fn_stg[i-1];
			end
		end
	end

	// tangential lanes
	lane_in_t          lin_a, lin_b;
	logic [DISP_W-1:0] frc_a, frc_b, slider_a, slider_b;

	always_comb begin
		lin_a.tang_disp  = ib.tang_disp_a;
		lin_a.slider_in  = ib.slider_in_a;
		lin_a.tang_stiff = ib.tang_stiff_a;
		lin_a.fric_coef  = ib.fric_coef_a;
		lin_b.tang_disp  = ib.tang_disp_b;
		lin_b.slider_in  = ib.slider_in_b;
		lin_b.tang_stiff = ib.tang_stiff_b;
		lin_b.fric_coef  = ib.fric_coef_b;
	end

	cff_lane #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_lane_a (
		.clk   (clk),
		.en    (en),
		.lin   (lin_a),
		.fn    (fn_s3),
		.frc   (frc_a),
		.slider(slider_a)
	);

	cff_lane #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_lane_b (
		.clk   (clk),
		.en    (en),
		.lin   (lin_b),
		.fn    (fn_s3),
		.frc   (frc_b),
		.slider(slider_b)
	);

	// merge normal and lane results into one beat
	res_t res, out_res;

	always_comb begin
		res.normal_force = fn_stg[LAT];
		res.tang_force_a = frc_a;
		res.tang_force_b = frc_b;
		res.slider_out_a = slider_a;
		res.slider_out_b = slider_b;
	end

	cff_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_q[LAT]),
		.in_data  (res),
		.in_ready (en),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (out_res)
	);

	assign m_axis_tdata = {{(OUT_W - $bits(res_t)){1'b0}}, out_res};

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without an output stall");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_q[1])
		else $error("accepted beat missing from first stage");

	a_no_contact_no_friction: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAT] && (fn_stg[LAT] == '0) |-> (frc_a == '0) && (frc_b == '0))
		else $error("tangential force without normal force");

	a_fn_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_res.normal_force <= SAT_MAX))
		else $error("normal force above saturation limit");

endmodule

`default_nettype wire
